// ----- hdl/leb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the line edit buffer: sizes, command and
// status codes, sequencer states and the text RAM request. No dependencies.
package leb_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int POS_W    = 9;
	localparam int CHAR_W   = 8;
	localparam int IDX_W    = 8;
	localparam int CMD_W    = 3;
	localparam int STAT_W   = 2;

	localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

	typedef enum logic [CMD_W-1:0] {
		CMD_LEFT  = 3'd0,
		CMD_RIGHT = 3'd1,
		CMD_TYPE  = 3'd2,
		CMD_BKSP  = 3'd3,
		CMD_HOME  = 3'd4,
		CMD_END   = 3'd5,
		CMD_READ  = 3'd6
	} leb_cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} leb_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_DEL_RD,
		S_DEL_WR,
		S_DEL_FIN,
		S_RD_WAIT,
		S_DONE
	} leb_state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} leb_ram_req_t;

	typedef struct packed {
		logic              valid;
		logic [POS_W-1:0]  cursor_pos;
		logic [POS_W-1:0]  text_len;
		logic [CHAR_W-1:0] read_char;
		leb_status_t       status;
	} leb_result_t;

endpackage

// ----- hdl/leb_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the line edit buffer: command items in,
// result items out. Depends on leb_pkg.
interface leb_cmd_if
	import leb_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [POS_W-1:0]  step;
	logic [CHAR_W-1:0] ch;
	logic [IDX_W-1:0]  index;

	modport source (output valid, command, step, ch, index, input ready);
	modport sink   (input valid, command, step, ch, index, output ready);
endinterface

interface leb_rsp_if
	import leb_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  cursor_pos;
	logic [POS_W-1:0]  text_len;
	logic [CHAR_W-1:0] read_char;
	logic [STAT_W-1:0] status;

	modport source (output valid, cursor_pos, text_len, read_char, status, input ready);
	modport sink   (input valid, cursor_pos, text_len, read_char, status, output ready);
endinterface

// ----- hdl/line_edit_buffer_with_cursor.sv -----
`timescale 1ns / 1ps
// Top level of the line edit buffer: sequencer, text RAM and result register.
// Depends on leb_pkg, leb_if, leb_text_ram and leb_seq.
//
//   Channel  Dir  Handshake    Payload
//   cmd      in   valid/ready  command[2:0] step[8:0] ch[7:0] index[7:0]
//   rsp      out  valid/ready  cursor_pos[8:0] text_len[8:0] read_char[7:0] status[1:0]
//
// One command at a time. An in-range read adds a read-wait state, type shifts the
// tail right and then writes the character, backspace shifts it left and then
// shortens the text. The tail shift moves one character per read and write state
// through the single RAM read port and write port, stepped by one shared pointer adder.
// Reset clears cursor and length; the text RAM is not cleared and needs no pass.
// A result waits in the output register while the next command is taken.
module line_edit_buffer_with_cursor
	import leb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	leb_cmd_if.sink       cmd,
	leb_rsp_if.source     rsp
);

	leb_ram_req_t      ram_req;
	logic [CHAR_W-1:0] ram_rdata;
	leb_result_t       done;
	logic              done_ready;

	logic              rsp_valid_q;
	logic [POS_W-1:0]  cursor_pos_q;
	logic [POS_W-1:0]  text_len_q;
	logic [CHAR_W-1:0] read_char_q;
	leb_status_t       status_q;

	leb_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd.valid),
		.in_ready   (cmd.ready),
		.command    (cmd.command),
		.step       (cmd.step),
		.ch         (cmd.ch),
		.index      (cmd.index),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.done_ready (done_ready),
		.done       (done)
	);

	leb_text_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	assign done_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done.valid && done_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// hold the payload until the item is taken
	always_ff @(posedge clk) begin
		if (done.valid && done_ready) begin
			cursor_pos_q <= done.cursor_pos;
			text_len_q   <= done.text_len;
			read_char_q  <= done.read_char;
			status_q     <= done.status;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cursor_pos = cursor_pos_q;
	assign rsp.text_len   = text_len_q;
	assign rsp.read_char  = read_char_q;
	assign rsp.status     = status_q;

endmodule

// ----- hdl/leb_text_ram.sv -----
`timescale 1ns / 1ps
// Character store: one write port and one read port with registered read data.
// Depends on leb_pkg.
module leb_text_ram
	import leb_pkg::*;
(
	input  logic              clk,
	input  leb_ram_req_t      req,
	output logic [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ----- hdl/leb_seq.sv -----
`timescale 1ns / 1ps
// Command sequencer: cursor and length registers, the shared pointer adder and
// the state machine that walks tail shifts through the text RAM. Depends on leb_pkg.
module leb_seq
	import leb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  command,
	input  logic [POS_W-1:0]  step,
	input  logic [CHAR_W-1:0] ch,
	input  logic [IDX_W-1:0]  index,
	output leb_ram_req_t      ram_req,
	input  logic [CHAR_W-1:0] ram_rdata,
	input  logic              done_ready,
	output leb_result_t       done
);

	leb_state_t        state_q, state_d;
	leb_cmd_t          cmd_q;
	logic [POS_W-1:0]  step_q;
	logic [CHAR_W-1:0] ch_q;
	logic [IDX_W-1:0]  index_q;
	logic [POS_W-1:0]  cursor_q, cursor_d;
	logic [POS_W-1:0]  length_q, length_d;
	logic [POS_W-1:0]  ptr_q, ptr_d;
	logic [CHAR_W-1:0] rd_q, rd_d;
	leb_status_t       status_q, status_d;

	logic              ptr_down;
	logic [POS_W-1:0]  ptr_adj;
	logic [POS_W-1:0]  room;
	logic [POS_W-1:0]  length_m1;

	// Shared pointer unit: step down while opening a gap, up while closing one
	assign ptr_down  = (state_q == S_SHIFT_RD) || (state_q == S_SHIFT_WR);
	assign ptr_adj   = ptr_q + (ptr_down ? {POS_W{1'b1}} : POS_W'(1));
	assign room      = length_q - cursor_q;
	assign length_m1 = length_q - POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			length_q <= '0;
		end else begin
			state_q  <= state_d;
			cursor_q <= cursor_d;
			length_q <= length_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q   <= leb_cmd_t'(command);
			step_q  <= step;
			ch_q    <= ch;
			index_q <= index;
		end
		ptr_q    <= ptr_d;
		rd_q     <= rd_d;
		status_q <= status_d;
	end

	always_comb begin
		state_d  = state_q;
		cursor_d = cursor_q;
		length_d = length_q;
		ptr_d    = ptr_q;
		rd_d     = rd_q;
		status_d = status_q;
		in_ready = 1'b0;
		ram_req  = '0;
		done.valid      = 1'b0;
		done.cursor_pos = cursor_q;
		done.text_len   = length_q;
		done.read_char  = rd_q;
		done.status     = status_q;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				rd_d     = '0;
				status_d = ST_OK;
				state_d  = S_DONE;
				unique case (cmd_q)
					CMD_LEFT: begin
						cursor_d = (step_q > cursor_q) ? '0 : cursor_q - step_q;
					end
					CMD_RIGHT: begin
						cursor_d = (step_q > room) ? length_q : cursor_q + step_q;
					end
					CMD_TYPE: begin
						if (length_q >= CAP_POS) begin
							status_d = ST_FULL;
						end else begin
							ptr_d   = length_q;
							state_d = (length_q == cursor_q) ? S_PUT : S_SHIFT_RD;
						end
					end
					CMD_BKSP: begin
						if (cursor_q == '0 || length_q == '0) begin
							status_d = ST_EMPTY;
						end else begin
							ptr_d   = cursor_q - POS_W'(1);
							state_d = (cursor_q < length_q) ? S_DEL_RD : S_DEL_FIN;
						end
					end
					CMD_HOME: begin
						cursor_d = '0;
					end
					CMD_END: begin
						cursor_d = length_q;
					end
					CMD_READ: begin
						if ({1'b0, index_q} < length_q) begin
							ram_req.re    = 1'b1;
							ram_req.raddr = ADDR_W'(index_q);
							state_d       = S_RD_WAIT;
						end
					end
					default: begin
					end
				endcase
			end
			S_SHIFT_RD: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = ptr_adj[ADDR_W-1:0];
				state_d       = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				// move one character right and advance toward the cursor
				ram_req.we    = 1'b1;
				ram_req.waddr = ptr_q[ADDR_W-1:0];
				ram_req.wdata = ram_rdata;
				ptr_d         = ptr_adj;
				state_d       = (ptr_adj == cursor_q) ? S_PUT : S_SHIFT_RD;
			end
			S_PUT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cursor_q[ADDR_W-1:0];
				ram_req.wdata = ch_q;
				length_d      = length_q + POS_W'(1);
				cursor_d      = cursor_q + POS_W'(1);
				state_d       = S_DONE;
			end
			S_DEL_RD: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = ptr_adj[ADDR_W-1:0];
				state_d       = S_DEL_WR;
			end
			S_DEL_WR: begin
				// move one character left; stop once the last one is moved
				ram_req.we    = 1'b1;
				ram_req.waddr = ptr_q[ADDR_W-1:0];
				ram_req.wdata = ram_rdata;
				ptr_d         = ptr_adj;
				state_d       = (ptr_adj < length_m1) ? S_DEL_RD : S_DEL_FIN;
			end
			S_DEL_FIN: begin
				length_d = length_m1;
				cursor_d = cursor_q - POS_W'(1);
				state_d  = S_DONE;
			end
			S_RD_WAIT: begin
				rd_d    = ram_rdata;
				state_d = S_DONE;
			end
			S_DONE: begin
				done.valid = 1'b1;
				if (done_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/leb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the line edit buffer results, bound to the top level.
// Depends on leb_pkg and line_edit_buffer_with_cursor.
module leb_checker
	import leb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [POS_W-1:0]  cursor_pos,
	input logic [POS_W-1:0]  text_len,
	input logic [CHAR_W-1:0] read_char,
	input logic [STAT_W-1:0] status
);

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> text_len <= CAP_POS)
		else $error("text length beyond capacity");

	a_cursor_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cursor_pos <= text_len)
		else $error("cursor beyond text length");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> text_len == CAP_POS)
		else $error("insert rejected while buffer not full");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_pos)
			&& $stable(text_len) && $stable(read_char) && $stable(status))
		else $error("stalled result item changed");

endmodule

bind line_edit_buffer_with_cursor leb_checker u_leb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.cursor_pos (rsp.cursor_pos),
	.text_len   (rsp.text_len),
	.read_char  (rsp.read_char),
	.status     (rsp.status)
);

// ----- tb/leb_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the line edit buffer: watches the command and result channels,
// keeps its own copy of the text, cursor and length, and checks every result item.
// Depends on leb_pkg and the channel interfaces in leb_if.
module leb_edit_checker
	import leb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	leb_cmd_if   cmd,
	leb_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding,
	output int   results_seen
);

	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [POS_W-1:0]  text_len;
		logic [CHAR_W-1:0] read_char;
		logic [STAT_W-1:0] status;
	} edit_outcome_t;

	logic [CHAR_W-1:0] text_mem [CAPACITY];
	int unsigned       cur_pos;
	int unsigned       len_cnt;
	edit_outcome_t     outcome_q [$];

	// Apply one command to the shadow buffer and return what the block should report.
	function automatic edit_outcome_t apply_edit(input logic [CMD_W-1:0] op,
			input logic [POS_W-1:0] mv_step, input logic [CHAR_W-1:0] chr,
			input logic [IDX_W-1:0] pos);
		edit_outcome_t res;
		int unsigned   i;
		res.read_char = '0;
		res.status    = ST_OK;
		case (op)
			CMD_LEFT: begin
				cur_pos = (mv_step > cur_pos) ? 0 : cur_pos - mv_step;
			end
			CMD_RIGHT: begin
				cur_pos = (mv_step > len_cnt - cur_pos) ? len_cnt : cur_pos + mv_step;
			end
			CMD_TYPE: begin
				if (len_cnt >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (i = len_cnt; i > cur_pos; i--)
						text_mem[i] = text_mem[i-1];
					text_mem[cur_pos] = chr;
					len_cnt++;
					cur_pos++;
				end
			end
			CMD_BKSP: begin
				if (cur_pos == 0 || len_cnt == 0) begin
					res.status = ST_EMPTY;
				end else begin
					for (i = cur_pos - 1; i + 1 < len_cnt; i++)
						text_mem[i] = text_mem[i+1];
					len_cnt--;
					cur_pos--;
				end
			end
			CMD_HOME: begin
				cur_pos = 0;
			end
			CMD_END: begin
				cur_pos = len_cnt;
			end
			CMD_READ: begin
				if (pos < len_cnt)
					res.read_char = text_mem[pos];
			end
			default: begin
			end
		endcase
		res.cursor_pos = POS_W'(cur_pos);
		res.text_len   = POS_W'(len_cnt);
		return res;
	endfunction

	task automatic check_field(input string fname, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		edit_outcome_t want;
		if (!arst_n) begin
			cur_pos      = 0;
			len_cnt      = 0;
			outcome_q.delete();
			mismatches   = 0;
			outstanding  = 0;
			results_seen = 0;
		end else begin
			if (cmd.valid && cmd.ready)
				outcome_q.push_back(apply_edit(cmd.command, cmd.step, cmd.ch, cmd.index));
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					mismatches++;
					$display({"%0t: unexpected result, expected none, ",
						"actual cursor %0d len %0d char %0d status %0d"},
						$time, rsp.cursor_pos, rsp.text_len, rsp.read_char, rsp.status);
				end else begin
					want = outcome_q.pop_front();
					check_field("cursor_pos", want.cursor_pos, rsp.cursor_pos);
					check_field("text_len", want.text_len, rsp.text_len);
					check_field("read_char", POS_W'(want.read_char), POS_W'(rsp.read_char));
					check_field("status", POS_W'(want.status), POS_W'(rsp.status));
				end
			end
			outstanding = outcome_q.size();
		end
	end

endmodule

// ----- tb/line_edit_buffer_with_cursor_tb.sv -----
`timescale 1ns / 1ps
// Top of the line edit buffer testbench: clock, reset, command stimulus and
// result back-pressure. Depends on leb_pkg, leb_if, the block and leb_edit_checker.
module line_edit_buffer_with_cursor_tb;
	import leb_pkg::*;

	localparam int               LIMIT_CYCLES = 2_000_000;
	localparam int               DRAIN_CYCLES = 600;
	localparam int               LONG_HOLD    = 300;
	localparam logic [CMD_W-1:0] CMD_UNUSED   = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   results_seen;
	bit   calm;
	bit   tx_quiet;
	int   est_len;

	leb_cmd_if cmd_ch ();
	leb_rsp_if rsp_ch ();

	line_edit_buffer_with_cursor u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	leb_edit_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.rsp          (rsp_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	always #5 clk = ~clk;

	// Offer one item at a falling edge and hold it until accepted.
	task automatic send_edit(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] mv_step,
			input logic [CHAR_W-1:0] chr, input logic [IDX_W-1:0] pos);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_quiet = !tx_quiet;
		if (!calm && !tx_quiet && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid <= 1'b0;
			gap = $urandom_range(1, 11);
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.step    <= mv_step;
		cmd_ch.ch      <= chr;
		cmd_ch.index   <= pos;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
		if (op == CMD_TYPE && est_len < CAPACITY)
			est_len++;
		if (op == CMD_BKSP && est_len > 0)
			est_len--;
	endtask

	task automatic send_random_edit();
		int                r;
		logic [CMD_W-1:0]  op;
		logic [POS_W-1:0]  mv_step;
		logic [IDX_W-1:0]  pos;
		r = $urandom_range(0, 99);
		if (r < 25)      op = CMD_TYPE;
		else if (r < 40) op = CMD_BKSP;
		else if (r < 52) op = CMD_LEFT;
		else if (r < 64) op = CMD_RIGHT;
		else if (r < 70) op = CMD_HOME;
		else if (r < 76) op = CMD_END;
		else if (r < 96) op = CMD_READ;
		else             op = CMD_UNUSED;
		r = $urandom_range(0, 9);
		if (r < 7)      mv_step = POS_W'($urandom_range(0, 16));
		else if (r < 9) mv_step = POS_W'($urandom_range(0, CAPACITY));
		else            mv_step = POS_W'($urandom_range(CAPACITY + 1, 511));
		// aim half the reads at held text
		if ($urandom_range(0, 1) == 0 && est_len > 0)
			pos = IDX_W'($urandom_range(0, est_len - 1));
		else
			pos = IDX_W'($urandom_range(0, 255));
		send_edit(op, mv_step, CHAR_W'($urandom_range(0, 255)), pos);
	endtask

	// Result side: random stall bursts, quiet stretches and one long hold-off.
	initial begin : result_sink
		int stall_left;
		bit rx_quiet;
		bit long_hold_done;
		stall_left     = 0;
		rx_quiet       = 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0)
				rx_quiet = !rx_quiet;
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (!long_hold_done && results_seen >= 40) begin
				long_hold_done = 1'b1;
				stall_left     = LONG_HOLD - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && !rx_quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 10);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int n;
		cmd_ch.valid   = 1'b0;
		cmd_ch.command = CMD_HOME;
		cmd_ch.step    = '0;
		cmd_ch.ch      = '0;
		cmd_ch.index   = '0;
		rsp_ch.ready   = 1'b0;
		calm           = 1'b0;
		tx_quiet       = 1'b0;
		est_len        = 0;
		arst_n         = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty buffer: read past text, delete nothing, moves clamp at both ends; then type, read and delete in a short text
		send_edit(CMD_READ,   9'd0,   8'h00, 8'd0);
		send_edit(CMD_BKSP,   9'd0,   8'h00, 8'd0);
		send_edit(CMD_LEFT,   9'd256, 8'h00, 8'd0);
		send_edit(CMD_RIGHT,  9'd256, 8'h00, 8'd0);
		send_edit(CMD_UNUSED, 9'd511, 8'hFF, 8'hFF);
		send_edit(CMD_TYPE,   9'd0,   8'h00, 8'd0);
		send_edit(CMD_TYPE,   9'd0,   8'hFF, 8'd0);
		send_edit(CMD_TYPE,   9'd0,   8'hA5, 8'd0);
		send_edit(CMD_LEFT,   9'd1,   8'h00, 8'd0);
		send_edit(CMD_TYPE,   9'd0,   8'h5A, 8'd0);
		send_edit(CMD_READ,   9'd0,   8'h00, 8'd0);
		send_edit(CMD_READ,   9'd0,   8'h00, 8'd2);
		send_edit(CMD_READ,   9'd0,   8'h00, 8'd255);
		send_edit(CMD_HOME,   9'd0,   8'h00, 8'd0);
		send_edit(CMD_BKSP,   9'd0,   8'h00, 8'd0);
		send_edit(CMD_RIGHT,  9'd2,   8'h00, 8'd0);
		send_edit(CMD_BKSP,   9'd0,   8'h00, 8'd0);
		send_edit(CMD_RIGHT,  9'd511, 8'h00, 8'd0);
		send_edit(CMD_LEFT,   9'd0,   8'h00, 8'd0);
		send_edit(CMD_RIGHT,  9'd0,   8'h00, 8'd0);
		send_edit(CMD_END,    9'd0,   8'h00, 8'd0);
		send_edit(CMD_BKSP,   9'd0,   8'h00, 8'd0);
		send_edit(CMD_LEFT,   9'd511, 8'h00, 8'd0);
		send_edit(CMD_READ,   9'd0,   8'h00, 8'd1);

		// hold the sender until every result is back
		cmd_ch.valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);

		// fill to capacity, mostly at the end with a few short steps back
		send_edit(CMD_END, 9'd0, 8'h00, 8'd0);
		while (est_len < CAPACITY) begin
			if ($urandom_range(0, 9) == 0)
				send_edit(CMD_LEFT, POS_W'($urandom_range(1, 4)), 8'h00, 8'd0);
			else
				send_edit(CMD_TYPE, 9'd0, CHAR_W'($urandom_range(0, 255)), 8'd0);
		end
		repeat (4) send_edit(CMD_TYPE, 9'd0, CHAR_W'($urandom_range(0, 255)), 8'd0);
		send_edit(CMD_READ,  9'd0,   8'h00, 8'd255);
		send_edit(CMD_RIGHT, 9'd511, 8'h00, 8'd0);

		repeat (150) send_random_edit();

		cmd_ch.valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);

		// drain from the end, then delete past empty
		send_edit(CMD_END, 9'd0, 8'h00, 8'd0);
		n = CAPACITY + 3;
		repeat (n) send_edit(CMD_BKSP, POS_W'($urandom_range(0, 511)),
			CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 255)));

		calm = 1'b1;
		repeat (60) send_random_edit();
		cmd_ch.valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
